// ===== src/mmc_pkg.sv =====
package mmc_pkg;

  // result field widths are fixed by the interface
  localparam int OUT_BITS    = 20;
  localparam int STATUS_BITS = 2;
  localparam int CFG_BITS    = 16;
  localparam int CNT_BITS    = $clog2(OUT_BITS);

  localparam logic [CFG_BITS-1:0] CAL_RESET = 16'd3000;

  localparam logic ACT_CAL  = 1'b0;
  localparam logic ACT_MEAS = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_CALIBRATING = 2'd0,
    ST_CAL_DONE    = 2'd1,
    ST_MEAS_VALID  = 2'd2,
    ST_NOT_CAL     = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    cal_update;
    logic    cal_finish;
    logic    div_setup;
    logic    div_step;
    logic    out_load;
    status_t out_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic calibrated;
    logic cal_last;
    logic div_last;
  } stat_t;

endpackage

// ===== src/mmc_ctrl.sv =====
module mmc_ctrl
  import mmc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_action,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CAL   = 6'b000010,
    S_FIN   = 6'b000100,
    S_SETUP = 6'b001000,
    S_DIV   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t  state, state_next;
  status_t code, code_next;
  logic    out_valid_next;

  always_comb begin
    state_next     = state;
    code_next      = code;
    cmd            = '0;
    cmd.out_status = code;
    in_ready       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_action == ACT_CAL) begin
            state_next = S_CAL;
          end else if (!stat.calibrated) begin
            code_next  = ST_NOT_CAL;
            state_next = S_EMIT;
          end else begin
            state_next = S_SETUP;
          end
        end
      end
      S_CAL: begin
        cmd.cal_update = 1'b1;
        if (stat.cal_last) begin
          state_next = S_FIN;
        end else begin
          code_next  = ST_CALIBRATING;
          state_next = S_EMIT;
        end
      end
      S_FIN: begin
        cmd.cal_finish = 1'b1;
        code_next      = ST_CAL_DONE;
        state_next     = S_EMIT;
      end
      S_SETUP: begin
        cmd.div_setup = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          code_next  = ST_MEAS_VALID;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      code      <= ST_CALIBRATING;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      code      <= code_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== src/mmc_datapath.sv =====
module mmc_datapath
  import mmc_pkg::*;
#(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_BITS-1:0]        cfg_wdata,
  input  logic [3*SAMPLE_BITS-1:0]   in_samples,
  input  cmd_t                       cmd,
  output stat_t                      stat,
  output status_t                    res_status,
  output logic [3*OUT_BITS-1:0]      res_norm
);

  localparam int SB = SAMPLE_BITS;
  localparam int CW = SB + 1 + OUT_BITS;
  localparam int DX = SB + 1 + FRACTION_BITS + OUT_BITS;

  localparam logic signed [SB-1:0] MAX_INIT = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] MIN_INIT = {1'b0, {(SB-1){1'b1}}};
  localparam logic [OUT_BITS-1:0]  SAT_HI   = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0]  SAT_LO   = {1'b1, {(OUT_BITS-1){1'b0}}};

  logic [CFG_BITS-1:0] cal_samples;
  logic [CFG_BITS-1:0] remaining;
  logic                calibrated;
  logic [CNT_BITS-1:0] div_cnt;

  logic signed [SB-1:0] raw     [3];
  logic signed [SB-1:0] trk_max [3];
  logic signed [SB-1:0] trk_min [3];
  logic signed [SB-1:0] bias    [3];
  logic [SB-2:0]        rng     [3];
  logic [SB-1:0]        rem     [3];
  logic [OUT_BITS-1:0]  quo     [3];
  logic                 neg     [3];
  logic                 ovf     [3];
  logic [OUT_BITS-1:0]  norm    [3];
  status_t              out_status;

  // combinational results per axis
  logic                 run_start;
  logic [CFG_BITS-1:0]  rem_eff;
  logic signed [SB-1:0] max_next [3];
  logic signed [SB-1:0] min_next [3];
  logic signed [SB-1:0] bias_next [3];
  logic [SB-2:0]        rng_next [3];
  logic [SB:0]          sum      [3];
  logic [SB:0]          sum_adj  [3];
  logic [SB:0]          span     [3];
  logic [SB:0]          diff     [3];
  logic [SB:0]          mag      [3];
  logic                 ovf_next [3];
  logic [DX-1:0]        dext     [3];
  logic [SB:0]          rem_sh   [3];
  logic                 ge       [3];
  logic [SB:0]          rem_sub  [3];
  logic [OUT_BITS-1:0]  sat      [3];

  assign run_start = (remaining == '0);
  assign rem_eff   = !run_start ? remaining :
                     (cal_samples == '0) ? CFG_BITS'(1) : cal_samples;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // tracker update, reloaded at the start of a run
      max_next[i] = run_start ? MAX_INIT : trk_max[i];
      min_next[i] = run_start ? MIN_INIT : trk_min[i];
      if (raw[i] > max_next[i]) max_next[i] = raw[i];
      if (raw[i] < min_next[i]) min_next[i] = raw[i];

      // bias and half range, rounded toward zero
      sum[i]       = {trk_max[i][SB-1], trk_max[i]} + {trk_min[i][SB-1], trk_min[i]};
      sum_adj[i]   = sum[i] + {{SB{1'b0}}, sum[i][SB]};
      bias_next[i] = sum_adj[i][SB:1];
      span[i]      = {trk_max[i][SB-1], trk_max[i]} - {trk_min[i][SB-1], trk_min[i]};
      rng_next[i]  = span[i][SB-1:1];

      // divider set-up: magnitude and early overflow test
      diff[i]     = {raw[i][SB-1], raw[i]} - {bias[i][SB-1], bias[i]};
      mag[i]      = diff[i][SB] ? (~diff[i] + (SB+1)'(1)) : diff[i];
      ovf_next[i] = CW'(mag[i]) >= (CW'(rng[i]) << (OUT_BITS - FRACTION_BITS));
      dext[i]     = DX'(mag[i]) << FRACTION_BITS;

      // one restoring step
      rem_sh[i]  = {rem[i], quo[i][OUT_BITS-1]};
      ge[i]      = rem_sh[i] >= (SB+1)'(rng[i]);
      rem_sub[i] = ge[i] ? (rem_sh[i] - (SB+1)'(rng[i])) : rem_sh[i];

      // sign and saturation
      if (!neg[i]) begin
        sat[i] = (ovf[i] || quo[i][OUT_BITS-1]) ? SAT_HI : quo[i];
      end else begin
        sat[i] = (ovf[i] || (quo[i][OUT_BITS-1] && |quo[i][OUT_BITS-2:0])) ?
                 SAT_LO : (~quo[i] + OUT_BITS'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_samples <= CAL_RESET;
      remaining   <= '0;
      calibrated  <= 1'b0;
      div_cnt     <= '0;
      for (int i = 0; i < 3; i++) begin
        bias[i] <= '0;
        rng[i]  <= '0;
      end
    end else begin
      if (cfg_we) cal_samples <= cfg_wdata;
      if (cmd.cal_update) remaining <= rem_eff - CFG_BITS'(1);
      if (cmd.cal_finish) begin
        calibrated <= (rng_next[0] != '0) && (rng_next[1] != '0) && (rng_next[2] != '0);
        for (int i = 0; i < 3; i++) begin
          bias[i] <= bias_next[i];
          rng[i]  <= rng_next[i];
        end
      end
      if (cmd.div_setup) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.capture) raw[i] <= in_samples[i*SB +: SB];
      if (cmd.cal_update) begin
        trk_max[i] <= max_next[i];
        trk_min[i] <= min_next[i];
      end
      if (cmd.div_setup) begin
        neg[i] <= diff[i][SB];
        ovf[i] <= ovf_next[i];
        rem[i] <= dext[i][OUT_BITS +: SB];
        quo[i] <= dext[i][OUT_BITS-1:0];
      end else if (cmd.div_step) begin
        rem[i] <= rem_sub[i][SB-1:0];
        quo[i] <= {quo[i][OUT_BITS-2:0], ge[i]};
      end
      if (cmd.out_load) begin
        norm[i] <= (cmd.out_status == ST_MEAS_VALID) ? sat[i] : '0;
      end
    end
    if (cmd.out_load) out_status <= cmd.out_status;
  end

  assign stat.calibrated = calibrated;
  assign stat.cal_last   = (rem_eff == CFG_BITS'(1));
  assign stat.div_last   = (div_cnt == CNT_BITS'(OUT_BITS - 1));

  assign res_status = out_status;
  assign res_norm   = {norm[2], norm[1], norm[0]};

endmodule

// ===== src/magnetometer_minmax_calibration_core.sv =====
// channel   direction  tdata (low bit up)              tuser
// s_*       in         mag_x, mag_y, mag_z, zero pad    action
// m_*       out        norm_x, norm_y, norm_z, zero pad status
// cfg_*     in         samples per run (write only)     -
//
// one word in flight at a time; the next input word is taken while a result
// still waits on the output register
// calibration word: accept, tracker update, emit; the last of a run adds the bias step before emit
// measurement word: accept, divider set-up, the 20 restoring steps of the divider, emit
// (one quotient bit per cycle, three axes side by side); not calibrated: accept, then emit
// rst is synchronous: no run active, not calibrated, sample count 3000
// a stalled output holds the finished word; the divider then waits at emit
module magnetometer_minmax_calibration_core
  import mmc_pkg::*;
#(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 14,
  localparam int IN_W  = ((3*SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3*OUT_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_BITS-1:0]   cfg_wdata,   // samples per run
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,     // mag_x, mag_y, mag_z, pad
  input  logic [0:0]            s_tuser,     // action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,     // norm_x, norm_y, norm_z, pad
  output logic [STATUS_BITS-1:0] m_tuser     // status
);

  cmd_t                  cmd;
  stat_t                 stat;
  status_t               res_status;
  logic [3*OUT_BITS-1:0] res_norm;

  // sequencing: accept, tracker update / bias, divider steps, emit
  mmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_action (s_tuser[0]),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // trackers, calibration registers, divider lanes and the result register
  mmc_datapath #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_samples (s_tdata[3*SAMPLE_BITS-1:0]),
    .cmd        (cmd),
    .stat       (stat),
    .res_status (res_status),
    .res_norm   (res_norm)
  );

  assign m_tdata = OUT_W'(res_norm);
  assign m_tuser = res_status;

  // nothing new is taken while a word is being worked on
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken during processing");

  // the result register is only overwritten once its word has gone
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result overwritten before hand-off");

  // the divider only runs against a valid calibration
  assert property (@(posedge clk) disable iff (rst)
    (cmd.div_setup || cmd.div_step) |-> stat.calibrated)
    else $error("divider running while not calibrated");

  // normalized fields are zero on every status other than a measurement
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_MEAS_VALID) |-> (m_tdata == '0))
    else $error("non-zero norm on a status word");

endmodule

// ===== verif/mmc_calibration_checker.sv =====
module mmc_calibration_checker
  import mmc_pkg::*;
#(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 14,
  parameter int IN_W          = 48,
  parameter int OUT_W         = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_BITS-1:0]    cfg_wdata,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_W-1:0]        s_tdata,    // mag_x, mag_y, mag_z
  input  logic [0:0]             s_tuser,    // action
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_W-1:0]       m_tdata,    // norm_x, norm_y, norm_z, pad
  input  logic [STATUS_BITS-1:0] m_tuser,    // status
  output int                     errors,
  output int                     pending,
  output int                     runs_closed,
  output int                     readings
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint NORM_MAX = (longint'(1) <<< (OUT_BITS - 1)) - 1;
  localparam longint NORM_MIN = -(longint'(1) <<< (OUT_BITS - 1));

  typedef struct packed {
    status_t             status;
    logic [OUT_BITS-1:0] norm_x;
    logic [OUT_BITS-1:0] norm_y;
    logic [OUT_BITS-1:0] norm_z;
  } reading_t;

  reading_t readings_due[$];

  logic [CFG_BITS-1:0]           run_length;
  logic [CFG_BITS-1:0]           samples_left;
  logic signed [SAMPLE_BITS-1:0] peak_hi [3];
  logic signed [SAMPLE_BITS-1:0] peak_lo [3];
  logic signed [SAMPLE_BITS-1:0] axis_offset [3];
  logic [SAMPLE_BITS-2:0]        axis_half [3];
  logic                          calibrated;

  function automatic void reload_trackers();
    int a;
    for (a = 0; a < 3; a++) begin
      peak_hi[a] = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      peak_lo[a] = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  // updates the tracker state and returns the word the block owes for this input
  function automatic reading_t next_reading(input logic act, input logic [IN_W-1:0] data);
    reading_t                      r;
    logic signed [SAMPLE_BITS-1:0] raw [3];
    logic [OUT_BITS-1:0]           norm [3];
    longint                        num;
    longint                        q;
    int                            a;
    r = '0;
    for (a = 0; a < 3; a++) begin
      raw[a]  = data[a*SAMPLE_BITS +: SAMPLE_BITS];
      norm[a] = '0;
    end
    if (act == ACT_CAL) begin
      if (samples_left == '0) begin
        reload_trackers();
        samples_left = (run_length == '0) ? CFG_BITS'(1) : run_length;
      end
      for (a = 0; a < 3; a++) begin
        if (raw[a] > peak_hi[a]) peak_hi[a] = raw[a];
        if (raw[a] < peak_lo[a]) peak_lo[a] = raw[a];
      end
      samples_left = samples_left - CFG_BITS'(1);
      if (samples_left != '0) begin
        r.status = ST_CALIBRATING;
      end else begin
        // both halves truncate toward zero
        for (a = 0; a < 3; a++) begin
          axis_offset[a] = SAMPLE_BITS'((longint'(peak_hi[a]) + longint'(peak_lo[a])) / 2);
          axis_half[a]   = (SAMPLE_BITS-1)'((longint'(peak_hi[a]) - longint'(peak_lo[a])) / 2);
        end
        calibrated = (axis_half[0] != '0) && (axis_half[1] != '0) && (axis_half[2] != '0);
        r.status = ST_CAL_DONE;
      end
    end else if (!calibrated) begin
      r.status = ST_NOT_CAL;
    end else begin
      for (a = 0; a < 3; a++) begin
        num = (longint'(raw[a]) - longint'(axis_offset[a])) * (longint'(1) <<< FRACTION_BITS);
        q   = (axis_half[a] != '0) ? num / longint'(axis_half[a]) : longint'(0);
        if (q > NORM_MAX) q = NORM_MAX;
        if (q < NORM_MIN) q = NORM_MIN;
        norm[a] = q[OUT_BITS-1:0];
      end
      r.status = ST_MEAS_VALID;
      r.norm_x = norm[0];
      r.norm_y = norm[1];
      r.norm_z = norm[2];
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    reading_t want;
    int       a;
    if (rst) begin
      reload_trackers();
      run_length   = CAL_RESET;
      samples_left = '0;
      for (a = 0; a < 3; a++) begin
        axis_offset[a] = '0;
        axis_half[a]   = '0;
      end
      calibrated = 1'b0;
      readings_due.delete();
      errors      = 0;
      runs_closed = 0;
      readings    = 0;
    end else begin
      if (cfg_we) run_length = cfg_wdata;
      if (m_tvalid && m_tready) begin
        if (readings_due.size() == 0) begin
          $error("unexpected word: status %0d, data %h", m_tuser, m_tdata);
          errors++;
        end else begin
          want = readings_due.pop_front();
          check_field("status", longint'(want.status), longint'(m_tuser));
          check_field("norm_x", longint'($signed(want.norm_x)),
                      longint'($signed(m_tdata[0*OUT_BITS +: OUT_BITS])));
          check_field("norm_y", longint'($signed(want.norm_y)),
                      longint'($signed(m_tdata[1*OUT_BITS +: OUT_BITS])));
          check_field("norm_z", longint'($signed(want.norm_z)),
                      longint'($signed(m_tdata[2*OUT_BITS +: OUT_BITS])));
          check_field("pad", longint'(0), longint'(m_tdata[OUT_W-1:3*OUT_BITS]));
          if (want.status == ST_CAL_DONE) runs_closed++;
          if (want.status == ST_MEAS_VALID) readings++;
        end
      end
      if (s_tvalid && s_tready) readings_due.push_back(next_reading(s_tuser[0], s_tdata));
    end
    pending = readings_due.size();
  end

endmodule

// ===== verif/magnetometer_minmax_calibration_core_tb.sv =====
module magnetometer_minmax_calibration_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mmc_pkg::*;

  // three 16-bit samples fill whole bytes; three 20-bit results pad to 64
  localparam int IN_W         = 48;
  localparam int OUT_W        = 64;
  localparam int RANDOM_WORDS = 1450;
  localparam int PHASE_WORDS  = 500;     // words per idling pattern
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int TAIL_CYCLES  = 40;      // quiet tail after the drain
  localparam int TIMEOUT_NS   = 2000000;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_BITS-1:0]    cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata   = '0;   // mag_x, mag_y, mag_z
  logic [0:0]             s_tuser   = '0;   // action
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_W-1:0]       m_tdata;          // norm_x, norm_y, norm_z, pad
  logic [STATUS_BITS-1:0] m_tuser;          // status

  int errors;
  int pending;
  int runs_closed;
  int readings;

  // idling percentages, changed as the run moves through its phases
  int send_idle_pct = 14;
  int recv_idle_pct = 86;
  int words_sent    = 0;
  bit hold_req      = 1'b0;

  // per-axis shape of the current calibration run
  int run_centre [3];
  int run_spread [3];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  magnetometer_minmax_calibration_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  mmc_calibration_checker #(
    .IN_W (IN_W),
    .OUT_W(OUT_W)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .errors     (errors),
    .pending    (pending),
    .runs_closed(runs_closed),
    .readings   (readings)
  );

  // offer one word from a falling edge, return at the falling edge after it is taken;
  // valid stays high so back-to-back words need no gap
  task automatic send_word(input logic act, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
    // swap the idling pattern, then drop idling altogether
    if (words_sent == PHASE_WORDS) begin
      send_idle_pct = 86;
      recv_idle_pct = 14;
    end else if (words_sent == 2 * PHASE_WORDS) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // stop offering and wait for every outstanding word to come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // the block is idle once nothing is outstanding, so the register may change
  task automatic write_count(input logic [CFG_BITS-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random sample around a centre, clamped to the 16-bit signed range
  function automatic logic [15:0] near(input int centre, input int spread);
    int v;
    v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // full-scale, near-zero-width, narrow and wide axes, chosen per axis
  function automatic void pick_profile();
    int a;
    for (a = 0; a < 3; a++) begin
      run_centre[a] = int'($urandom_range(0, 65535)) - 32768;
      case ($urandom_range(0, 9))
        0, 1:    run_spread[a] = 32768;
        2, 3:    run_spread[a] = $urandom_range(0, 3);
        4, 5, 6: run_spread[a] = $urandom_range(4, 400);
        default: run_spread[a] = $urandom_range(401, 20000);
      endcase
    end
  endfunction

  // readings mostly in and just beyond the calibrated span, some anywhere
  task automatic measure();
    logic [15:0] v [3];
    int          a;
    for (a = 0; a < 3; a++) begin
      case ($urandom_range(0, 7))
        0:       v[a] = 16'($urandom);
        1:       v[a] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        default: v[a] = near(run_centre[a], run_spread[a] * int'($urandom_range(1, 3)));
      endcase
    end
    send_word(ACT_MEAS, v[0], v[1], v[2]);
  endtask

  task automatic calibration_run(input int len, input int meas_pct);
    int k;
    for (k = 0; k < len; k++) begin
      send_word(ACT_CAL, near(run_centre[0], run_spread[0]), near(run_centre[1], run_spread[1]),
                near(run_centre[2], run_spread[2]));
      if ($urandom_range(0, 99) < meas_pct) measure();
    end
  endtask

  // receiver: random stalls, plus one long hold-off whenever asked
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int len;
    int eff_len;
    int random_end;
    int next_hold;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // nothing calibrated yet: extremes come back as not calibrated
    send_word(ACT_MEAS, -32768, 32767, 0);
    send_word(ACT_MEAS, 32767, -32768, -1);

    // count of zero acts as one; a single sample leaves every range at zero
    write_count(0);
    send_word(ACT_CAL, 0, 0, 0);
    send_word(ACT_MEAS, 1, 2, 3);

    // full-scale run: odd sum, bias truncates to zero, range 32767
    write_count(2);
    send_word(ACT_CAL, -32768, -32768, -32768);
    send_word(ACT_CAL, 32767, 32767, 32767);
    send_word(ACT_MEAS, 32767, -32768, 0);
    send_word(ACT_MEAS, -1, 1, 16383);

    // range of one on each axis, odd negative sum on y; readings saturate both ways
    write_count(3);
    send_word(ACT_CAL, 100, -50, -1);
    send_word(ACT_CAL, 102, -47, 1);
    send_word(ACT_CAL, 101, -49, 0);
    send_word(ACT_MEAS, 32767, -32768, 0);
    send_word(ACT_MEAS, 101, -48, 1);
    send_word(ACT_MEAS, -32768, 32767, -32768);

    // new run: readings keep the old calibration, a mid-run write waits for the next run
    write_count(2);
    send_word(ACT_CAL, -1000, 500, 3);
    send_word(ACT_MEAS, 102, -47, 1);
    write_count(5);
    // z stays flat, so this run ends not calibrated
    send_word(ACT_CAL, 1000, 700, 3);
    send_word(ACT_MEAS, 5, 5, 5);

    // five-sample run from the mid-run write
    send_word(ACT_CAL, -20000, -300, 7);
    send_word(ACT_CAL, 15000, 900, -7);
    send_word(ACT_CAL, 0, 0, 0);
    send_word(ACT_CAL, -32768, 32767, 100);
    send_word(ACT_CAL, 32767, -32768, -100);
    send_word(ACT_MEAS, 12345, -12345, 50);
    send_word(ACT_MEAS, -5, 5, -100);

    // random phases: a count, whole runs with readings mixed in, then loose readings
    random_end = words_sent + RANDOM_WORDS;
    next_hold  = words_sent + 300;
    while (words_sent < random_end) begin
      case ($urandom_range(0, 19))
        0:                      len = 0;
        1, 2, 3:                len = 1;
        4, 5, 6, 7, 8:          len = $urandom_range(2, 4);
        9, 10, 11, 12, 13, 14: len = $urandom_range(5, 16);
        15, 16, 17, 18:         len = $urandom_range(17, 64);
        default:                len = $urandom_range(65, 200);
      endcase
      eff_len = (len == 0) ? 1 : len;
      write_count(CFG_BITS'(len));
      repeat ($urandom_range(1, 3)) begin
        pick_profile();
        // sender keeps offering while the receiver sits still
        if (words_sent >= next_hold) begin
          hold_req  = 1'b1;
          next_hold = next_hold + 600;
        end
        calibration_run(eff_len, $urandom_range(0, 30));
        repeat ($urandom_range(0, 6)) measure();
      end
      // broken run: cut short, so the next count lands mid-run
      if ($urandom_range(0, 7) == 0) begin
        pick_profile();
        calibration_run($urandom_range(1, eff_len), 50);
      end
    end

    // largest count: the run stays open, readings use the last finished calibration
    write_count(16'hffff);
    pick_profile();
    calibration_run(12, 40);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d words: %0d calibration runs closed, %0d readings normalised",
             words_sent, runs_closed, readings);
    $display("sample counts from 0 to 65535, three idling patterns, long output hold-offs");
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== magnetometer_minmax_calibration_core.f =====
src/mmc_pkg.sv
src/mmc_ctrl.sv
src/mmc_datapath.sv
src/magnetometer_minmax_calibration_core.sv
verif/mmc_calibration_checker.sv
verif/magnetometer_minmax_calibration_core_tb.sv
